// ===== design/sorm_pkg.sv =====
package sorm_pkg;

  localparam int SIDE_W = 4;
  localparam int VALUE_W = 32;
  localparam int MAX_SIDE_DEFAULT = 8;
  localparam int REG_ADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [SIDE_W-1:0] SIZE_RESET = 4'd4;

  localparam logic REG_MATRIX_SIZE = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  typedef struct packed {
    logic              bank;
    logic [SIDE_W-1:0] side;
    logic              anti;
  } job_t;

  typedef struct packed {
    logic busy;
    logic bank;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RING,
    BK_CENTRE
  } bk_state_t;

endpackage

// ===== design/spiral_order_matrix_reader_unit.sv =====
// Channel    Direction  Handshake           Payload
// input      in         in_valid/in_stall   element_value
// output     out        out_valid/out_stall out_value, last
// config     in/out     APB write/read      matrix_size, direction
//
// Elements are taken at one per cycle, when in_stall is low, into one of two store
// banks; the item that completes an N by N matrix queues a job and loading continues
// in the other bank. The spiral sequencer then issues one store read per cycle while
// the output queue has room, so N*N results leave at one per cycle while out_stall is low.
// Input stalls while two matrices await or undergo emission. Reset clears control
// state only; the store is not cleared. Output stall backs up through a three-entry queue.
module spiral_order_matrix_reader_unit #(
  parameter int MaxSide = sorm_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sorm_pkg::VALUE_W-1:0] element_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sorm_pkg::VALUE_W-1:0] out_value,
  output logic                                last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sorm_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [sorm_pkg::PDATA_W-1:0]        pwdata,
  output logic [sorm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int CellAw = (MaxSide > 1) ? $clog2(MaxSide * MaxSide) : 1;
  localparam int StoreDepth = 2 * MaxSide * MaxSide;

  logic [sorm_pkg::SIDE_W-1:0] matrix_size;
  logic                        direction;
  logic                        reg_index;

  logic                        job_push;
  sorm_pkg::job_t              push_job;
  logic                        job_pop;
  logic                        head_valid;
  sorm_pkg::job_t              head_job;
  logic [1:0]                  q_count;
  sorm_pkg::back_status_t      back_status;

  logic                        wr_en;
  logic [CellAw:0]             wr_addr;
  logic [sorm_pkg::VALUE_W-1:0] wr_data;
  logic                        rd_en;
  logic [CellAw:0]             rd_addr;
  logic [sorm_pkg::VALUE_W-1:0] rd_data;

  assign pready = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= sorm_pkg::SIZE_RESET;
      direction <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        sorm_pkg::REG_MATRIX_SIZE: matrix_size <= pwdata[sorm_pkg::SIDE_W-1:0];
        sorm_pkg::REG_DIRECTION: direction <= pwdata[0];
        default: direction <= direction;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      sorm_pkg::REG_MATRIX_SIZE: prdata = sorm_pkg::PDATA_W'(matrix_size);
      sorm_pkg::REG_DIRECTION: prdata = sorm_pkg::PDATA_W'(direction);
      default: prdata = '0;
    endcase
  end

  sorm_front #(
    .MaxSide(MaxSide),
    .CellAw (CellAw)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element_value(element_value),
    .matrix_size  (matrix_size),
    .direction    (direction),
    .q_count      (q_count),
    .back_busy    (back_status.busy),
    .job_push     (job_push),
    .job          (push_job),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  sorm_job_q u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .head_valid(head_valid),
    .head_job  (head_job),
    .count     (q_count)
  );

  sorm_ram #(
    .Width(sorm_pkg::VALUE_W),
    .Depth(StoreDepth),
    .AddrW(CellAw + 1)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sorm_back #(
    .MaxSide(MaxSide),
    .CellAw (CellAw)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(head_valid),
    .job      (head_job),
    .job_pop  (job_pop),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .last     (last),
    .status   (back_status)
  );

`ifndef SYNTHESIS
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (wr_en && back_status.busy) |-> (wr_addr[CellAw] != back_status.bank))
    else $error("store write hits the bank under emission");

  a_no_overbook: assert property (@(posedge clk) disable iff (rst)
    !((q_count == 2'd2) && back_status.busy))
    else $error("more than two matrices outstanding");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (q_count != 2'd2))
    else $error("job pushed into a full queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule

// ===== design/sorm_ram.sv =====
module sorm_ram #(
  parameter int Width = 32,
  parameter int Depth = 128,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sorm_front.sv =====
module sorm_front #(
  parameter int MaxSide = sorm_pkg::MAX_SIDE_DEFAULT,
  parameter int CellAw = (MaxSide > 1) ? $clog2(MaxSide * MaxSide) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [sorm_pkg::VALUE_W-1:0] element_value,
  input  logic [sorm_pkg::SIDE_W-1:0]   matrix_size,
  input  logic                          direction,
  input  logic [1:0]                    q_count,
  input  logic                          back_busy,
  output logic                          job_push,
  output sorm_pkg::job_t                job,
  output logic                          wr_en,
  output logic [CellAw:0]               wr_addr,
  output logic [sorm_pkg::VALUE_W-1:0]  wr_data
);

  localparam int LcW = $clog2(MaxSide * MaxSide + 1);
  localparam int SqW = 2 * sorm_pkg::SIDE_W;

  logic [LcW-1:0] load_count;
  logic [LcW-1:0] load_count_inc;
  logic           bank;
  logic [sorm_pkg::SIDE_W-1:0] side;
  logic [SqW-1:0] side_sq;
  logic [2:0]     outstanding;
  logic           accept;
  logic           complete;

  always_comb begin
    if (matrix_size == '0) begin
      side = sorm_pkg::SIDE_W'(1);
    end else if (matrix_size > sorm_pkg::SIDE_W'(MaxSide)) begin
      side = sorm_pkg::SIDE_W'(MaxSide);
    end else begin
      side = matrix_size;
    end
  end

  assign side_sq = SqW'(side) * SqW'(side);
  assign outstanding = 3'(q_count) + 3'(back_busy);
  assign in_stall = (outstanding >= 3'd2);
  assign accept = in_valid && !in_stall;
  assign load_count_inc = load_count + LcW'(1);
  assign complete = (SqW'(load_count_inc) >= side_sq);

  assign wr_en = accept;
  assign wr_addr = {bank, load_count[CellAw-1:0]};
  assign wr_data = element_value;

  assign job_push = accept && complete;
  assign job.bank = bank;
  assign job.side = side;
  assign job.anti = direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        load_count <= '0;
        bank <= !bank;
      end else begin
        load_count <= load_count_inc;
      end
    end
  end

endmodule

// ===== design/sorm_job_q.sv =====
module sorm_job_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sorm_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output sorm_pkg::job_t head_job,
  output logic [1:0]     count
);

  sorm_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;

  assign head_valid = (count != 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/sorm_back.sv =====
module sorm_back #(
  parameter int MaxSide = sorm_pkg::MAX_SIDE_DEFAULT,
  parameter int CellAw = (MaxSide > 1) ? $clog2(MaxSide * MaxSide) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  sorm_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          rd_en,
  output logic [CellAw:0]               rd_addr,
  input  logic [sorm_pkg::VALUE_W-1:0]  rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [sorm_pkg::VALUE_W-1:0] out_value,
  output logic                          last,
  output sorm_pkg::back_status_t        status
);

  localparam int CoordW = (MaxSide > 1) ? $clog2(MaxSide) : 1;

  sorm_pkg::bk_state_t state;
  sorm_pkg::bk_state_t state_next;
  sorm_pkg::job_t      job_q;

  logic [CoordW-1:0] ring;
  logic [1:0]        seg;
  logic [CoordW-1:0] t;
  logic [CoordW-1:0] half;
  logic [CoordW-1:0] hi;
  logic [CoordW-1:0] len_m1;
  logic [CoordW-1:0] row;
  logic [CoordW-1:0] col;
  logic              seg_end;
  logic              ring_end;
  logic              last_ring;
  logic              odd;
  logic              issue;
  logic              issue_last;

  logic [sorm_pkg::VALUE_W-1:0] fifo_value [3];
  logic        fifo_last [3];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [1:0]  count;
  logic [2:0]  occupancy;
  logic        inflight;
  logic        inflight_last;
  logic        pop;

  assign half = CoordW'(job_q.side >> 1);
  assign hi = CoordW'(job_q.side - sorm_pkg::SIDE_W'(1)) - ring;
  assign len_m1 = hi - ring - CoordW'(1);
  assign odd = job_q.side[0];
  assign seg_end = (t == len_m1);
  assign ring_end = seg_end && (seg == 2'd3);
  assign last_ring = (ring == half - CoordW'(1));
  assign occupancy = 3'(count) + 3'(inflight);

  always_comb begin
    state_next = state;
    case (state)
      sorm_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_next = (job.side[sorm_pkg::SIDE_W-1:1] == '0) ?
                       sorm_pkg::BK_CENTRE : sorm_pkg::BK_RING;
        end
      end
      sorm_pkg::BK_RING: begin
        if (issue && ring_end && last_ring) begin
          state_next = odd ? sorm_pkg::BK_CENTRE : sorm_pkg::BK_IDLE;
        end
      end
      sorm_pkg::BK_CENTRE: begin
        if (issue) begin
          state_next = sorm_pkg::BK_IDLE;
        end
      end
      default: state_next = sorm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    issue = 1'b0;
    issue_last = 1'b0;
    row = half;
    col = half;
    case (state)
      sorm_pkg::BK_IDLE: begin
        job_pop = job_valid;
      end
      sorm_pkg::BK_RING: begin
        issue = (occupancy < 3'd3);
        issue_last = ring_end && last_ring && !odd;
        case (seg)
          2'd0: begin
            row = ring;
            col = job_q.anti ? hi - t : ring + t;
          end
          2'd1: begin
            row = ring + t;
            col = job_q.anti ? ring : hi;
          end
          2'd2: begin
            row = hi;
            col = job_q.anti ? ring + t : hi - t;
          end
          default: begin
            row = hi - t;
            col = job_q.anti ? hi : ring;
          end
        endcase
      end
      sorm_pkg::BK_CENTRE: begin
        issue = (occupancy < 3'd3);
        issue_last = 1'b1;
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  assign rd_en = issue;
  assign rd_addr = {job_q.bank,
                    CellAw'(row) * CellAw'(job_q.side) + CellAw'(col)};

  assign status.busy = (state != sorm_pkg::BK_IDLE);
  assign status.bank = job_q.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sorm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_q <= job;
      ring <= '0;
      seg <= 2'd0;
      t <= '0;
    end else if (issue && (state == sorm_pkg::BK_RING)) begin
      if (seg_end) begin
        t <= '0;
        if (seg == 2'd3) begin
          seg <= 2'd0;
          ring <= ring + CoordW'(1);
        end else begin
          seg <= seg + 2'd1;
        end
      end else begin
        t <= t + CoordW'(1);
      end
    end
  end

  assign out_valid = (count != 2'd0);
  assign out_value = fifo_value[rd_ptr];
  assign last = fifo_last[rd_ptr];
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (inflight) begin
      fifo_value[wr_ptr] <= rd_data;
      fifo_last[wr_ptr] <= inflight_last;
    end
    inflight_last <= issue_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 2'd0;
    end else begin
      inflight <= issue;
      if (inflight) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + 2'(inflight) - 2'(pop);
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 280;
  localparam int STORE_DEPTH = sorm_pkg::MAX_SIDE_DEFAULT * sorm_pkg::MAX_SIDE_DEFAULT;
  localparam logic [sorm_pkg::REG_ADDR_W-1:0] ADDR_SIZE = {sorm_pkg::REG_MATRIX_SIZE, 2'b00};
  localparam logic [sorm_pkg::REG_ADDR_W-1:0] ADDR_DIR = {sorm_pkg::REG_DIRECTION, 2'b00};

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_READ,
    ROW_ELEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [sorm_pkg::REG_ADDR_W-1:0] addr;
    logic [sorm_pkg::VALUE_W-1:0]    data;
    logic                            typed;
    logic [sorm_pkg::VALUE_W-1:0]    want;
    logic                            want_last;
  } stim_row_t;

  typedef struct packed {
    logic [sorm_pkg::VALUE_W-1:0] value;
    logic                         last;
  } spiral_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [sorm_pkg::VALUE_W-1:0] element_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [sorm_pkg::VALUE_W-1:0] out_value;
  logic                                last;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [sorm_pkg::REG_ADDR_W-1:0]     paddr = '0;
  logic [sorm_pkg::PDATA_W-1:0]        pwdata = '0;
  logic [sorm_pkg::PDATA_W-1:0]        prdata;
  logic                                pready;

  spiral_order_matrix_reader_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element_value(element_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  logic [sorm_pkg::VALUE_W-1:0] matrix_copy [STORE_DEPTH];
  logic [6:0]                   load_cnt;
  logic [sorm_pkg::SIDE_W-1:0]  side_reg;
  logic                         dir_reg;
  spiral_result_t               pending_results [$];
  stim_row_t                    directed_rows [$];

  int mismatches = 0;
  int send_idle_pct = 7;
  int recv_stall_pct = 82;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  function automatic int side_now();
    if (side_reg == '0) return 1;
    if (int'(side_reg) > sorm_pkg::MAX_SIDE_DEFAULT) return sorm_pkg::MAX_SIDE_DEFAULT;
    return int'(side_reg);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Stores one element and, on the completing transfer, queues the spiral if keep is set.
  task automatic take_element(input logic [sorm_pkg::VALUE_W-1:0] v, input bit keep);
    int n;
    int ring;
    int lo;
    int hi;
    int j;
    int cells [$];
    spiral_result_t res;
    n = side_now();
    matrix_copy[load_cnt[5:0]] = v;
    load_cnt = load_cnt + 7'd1;
    if (int'(load_cnt) >= n * n) begin
      load_cnt = '0;
      for (ring = 0; ring < n / 2; ring++) begin
        lo = ring;
        hi = n - 1 - ring;
        if (!dir_reg) begin
          for (j = lo; j < hi; j++) cells.push_back(lo * n + j);
          for (j = lo; j < hi; j++) cells.push_back(j * n + hi);
          for (j = hi; j > lo; j--) cells.push_back(hi * n + j);
          for (j = hi; j > lo; j--) cells.push_back(j * n + lo);
        end else begin
          for (j = hi; j > lo; j--) cells.push_back(lo * n + j);
          for (j = lo; j < hi; j++) cells.push_back(j * n + lo);
          for (j = lo; j < hi; j++) cells.push_back(hi * n + j);
          for (j = hi; j > lo; j--) cells.push_back(j * n + hi);
        end
      end
      if (n % 2 == 1) cells.push_back((n / 2) * n + n / 2);
      if (keep) begin
        foreach (cells[k]) begin
          res.value = matrix_copy[cells[k]];
          res.last = (k == cells.size() - 1);
          pending_results.push_back(res);
        end
      end
    end
  endtask

  task automatic push_element(input logic [sorm_pkg::VALUE_W-1:0] v, input logic typed,
                              input logic [sorm_pkg::VALUE_W-1:0] want,
                              input logic want_last);
    spiral_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      take_element(v, 1'b0);
      res.value = want;
      res.last = want_last;
      pending_results.push_back(res);
    end else begin
      take_element(v, 1'b1);
    end
  endtask

  // Waits until every expected transfer has left, then lets the block settle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [sorm_pkg::REG_ADDR_W-1:0] addr,
                           input logic [sorm_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SIZE) side_reg = data[sorm_pkg::SIDE_W-1:0];
    else if (addr == ADDR_DIR) dir_reg = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [sorm_pkg::REG_ADDR_W-1:0] addr,
                          input logic [sorm_pkg::PDATA_W-1:0] want);
    logic [sorm_pkg::PDATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== want) report_mismatch("register read", want, got);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [sorm_pkg::REG_ADDR_W-1:0] addr,
                         input logic [sorm_pkg::VALUE_W-1:0] data, input logic typed,
                         input logic [sorm_pkg::VALUE_W-1:0] want, input logic want_last);
    stim_row_t row;
    row.kind = kind;
    row.addr = addr;
    row.data = data;
    row.typed = typed;
    row.want = want;
    row.want_last = want_last;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin : check_output
    spiral_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, out_value);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) report_mismatch("out_value", exp_res.value, out_value);
        if (last !== exp_res.last) report_mismatch("last", 32'(exp_res.last), 32'(last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t                    row;
    int                           section;
    int                           section_items;
    int                           big_runs;
    int                           pick;
    int                           n;
    int                           count;
    bit                           squeeze;
    logic [sorm_pkg::SIDE_W-1:0]  size;
    logic [sorm_pkg::VALUE_W-1:0] v;

    load_cnt = '0;
    side_reg = sorm_pkg::SIZE_RESET;
    dir_reg = 1'b0;
    big_runs = 0;

    add_row(ROW_READ, ADDR_SIZE, '0, 1'b1, 32'(sorm_pkg::SIZE_RESET), 1'b0);
    add_row(ROW_READ, ADDR_DIR, '0, 1'b1, 32'd0, 1'b0);
    add_row(ROW_WRITE, ADDR_SIZE, 32'd1, 1'b0, '0, 1'b0);
    add_row(ROW_ELEM, '0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1);
    add_row(ROW_ELEM, '0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b1);
    add_row(ROW_ELEM, '0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1);
    add_row(ROW_ELEM, '0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1);
    // A side of zero is taken as one.
    add_row(ROW_WRITE, ADDR_SIZE, 32'd0, 1'b0, '0, 1'b0);
    add_row(ROW_READ, ADDR_SIZE, '0, 1'b1, 32'd0, 1'b0);
    add_row(ROW_ELEM, '0, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1);
    add_row(ROW_WRITE, ADDR_SIZE, 32'd2, 1'b0, '0, 1'b0);
    add_row(ROW_WRITE, ADDR_DIR, 32'd1, 1'b0, '0, 1'b0);
    add_row(ROW_READ, ADDR_DIR, '0, 1'b1, 32'd1, 1'b0);
    add_row(ROW_ELEM, '0, 32'ha5a5_a5a5, 1'b0, '0, 1'b0);
    add_row(ROW_ELEM, '0, 32'h5a5a_5a5a, 1'b0, '0, 1'b0);
    add_row(ROW_ELEM, '0, 32'h0000_0001, 1'b0, '0, 1'b0);
    add_row(ROW_ELEM, '0, 32'hffff_fffe, 1'b0, '0, 1'b0);
    add_row(ROW_WRITE, ADDR_SIZE, 32'd3, 1'b0, '0, 1'b0);
    add_row(ROW_WRITE, ADDR_DIR, 32'd0, 1'b0, '0, 1'b0);
    for (int i = 1; i <= 9; i++) begin
      add_row(ROW_ELEM, '0, 32'(i) * 32'h1111_1111 ^ {32{i[0]}}, 1'b0, '0, 1'b0);
    end
    // Part of a three by three load, then the side and direction change under it.
    for (int i = 0; i < 5; i++) begin
      add_row(ROW_ELEM, '0, 32'hc000_0000 + 32'(i), 1'b0, '0, 1'b0);
    end
    add_row(ROW_WRITE, ADDR_SIZE, 32'd2, 1'b0, '0, 1'b0);
    add_row(ROW_WRITE, ADDR_DIR, 32'd1, 1'b0, '0, 1'b0);
    add_row(ROW_ELEM, '0, 32'h0bad_cafe, 1'b0, '0, 1'b0);
    add_row(ROW_WRITE, ADDR_SIZE, 32'd15, 1'b0, '0, 1'b0);
    add_row(ROW_READ, ADDR_SIZE, '0, 1'b1, 32'd15, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WRITE: begin
          settle();
          apb_write(row.addr, row.data);
        end
        ROW_READ: begin
          settle();
          apb_read(row.addr, row.want);
        end
        default: begin
          push_element(row.data, row.typed, row.want, row.want_last);
        end
      endcase
    end

    for (section = 0; section < 3; section++) begin
      case (section)
        0: begin
          send_idle_pct = 7;
          recv_stall_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      section_items = 0;
      while (section_items < RANDOM_ITEMS / 3) begin
        squeeze = (section == 2 && section_items == 0);
        settle();
        pick = $urandom_range(99);
        if (squeeze) begin
          size = 4'd2;
        end else if (pick < 5) begin
          size = 4'd0;
        end else if (pick < 10 && big_runs < 3) begin
          size = (pick < 8) ? 4'(pick + 8) : 4'd15;
          big_runs++;
        end else if (pick < 25) begin
          size = 4'($urandom_range(5, 7));
        end else begin
          size = 4'($urandom_range(1, 4));
        end
        apb_write(ADDR_SIZE, 32'(size));
        apb_write(ADDR_DIR, 32'($urandom_range(1)));
        n = side_now();
        count = (int'(load_cnt) < n * n) ? n * n - int'(load_cnt) : 1;
        if (squeeze) count += 6 * n * n;
        else count += int'($urandom_range(2)) * n * n;
        if ($urandom_range(4) == 0) count += int'($urandom_range(n * n - 1));
        // The receiver holds off while the sender keeps offering, so the
        // block fills up and stalls its input.
        if (squeeze) hold_requests++;
        repeat (count) begin
          case ($urandom_range(15))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0000_0000;
            3: v = 32'hffff_ffff;
            default: v = $urandom;
          endcase
          push_element(v, 1'b0, '0, 1'b0);
        end
        section_items += count;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
